>>> hw/rtl/sm3_pkg.sv
// Shared types, constants and word functions of the SM3 hash engine.
// Depends on nothing; used by sm3_round and sm3_hash_engine.
package sm3_pkg;

  typedef logic [31:0] word_t;
  // Eight 32-bit words, index 0 is A (or the first chaining word).
  typedef logic [0:7][31:0] regs_t;
  // Sixteen-word message window, index 0 is the oldest word.
  typedef logic [0:15][31:0] window_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROUND,
    S_EMIT
  } state_t;

  localparam word_t T_LOW  = 32'h79CC4519;
  localparam word_t T_HIGH = 32'h7A879D8A;

  localparam regs_t IV = {
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned ROUNDS      = 64;
  localparam int unsigned DIGEST_WORDS = 8;

  function automatic word_t rotl(word_t x, logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic word_t p0(word_t x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic word_t p1(word_t x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

  // Next expanded word W[j+16] from the window holding W[j] .. W[j+15].
  function automatic word_t expand(window_t w);
    return p1(w[0] ^ w[7] ^ rotl(w[13], 5'd15)) ^ rotl(w[3], 5'd7) ^ w[10];
  endfunction

endpackage

>>> hw/rtl/sm3_round.sv
// One SM3 compression round: FF, GG, SS1/SS2 and the register update.
// Depends on sm3_pkg.
module sm3_round (
  input  sm3_pkg::regs_t     v,
  input  sm3_pkg::word_t     w_j,
  input  sm3_pkg::word_t     w_j4,
  input  logic [5:0]         j,
  output sm3_pkg::regs_t     v_nxt
);

  sm3_pkg::word_t ra, tj, ss1, ss2, ff, gg, tt1, tt2;
  logic           low_half;

  always_comb begin
    low_half = (j[5:4] == 2'b00);
    tj       = low_half ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
    ra       = sm3_pkg::rotl(v[0], 5'd12);
    ss1      = sm3_pkg::rotl(ra + v[4] + sm3_pkg::rotl(tj, j[4:0]), 5'd7);
    ss2      = ss1 ^ ra;
    if (low_half) begin
      ff = v[0] ^ v[1] ^ v[2];
      gg = v[4] ^ v[5] ^ v[6];
    end else begin
      ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
      gg = (v[4] & v[5]) | (~v[4] & v[6]);
    end
    tt1 = ff + v[3] + ss2 + (w_j ^ w_j4);
    tt2 = gg + v[7] + ss1 + w_j;

    v_nxt[0] = tt1;
    v_nxt[1] = v[0];
    v_nxt[2] = sm3_pkg::rotl(v[1], 5'd9);
    v_nxt[3] = v[2];
    v_nxt[4] = sm3_pkg::p0(tt2);
    v_nxt[5] = v[4];
    v_nxt[6] = sm3_pkg::rotl(v[5], 5'd19);
    v_nxt[7] = v[6];
  end

endmodule

>>> hw/rtl/sm3_hash_engine.sv
// SM3 hash engine: one input word per cycle while idle, 64 rounds per block, 8 digest
// words out. The sixteenth word of a block starts 64 rounds, one per cycle through the
// shared round unit; further words are stalled until the engine is idle again. A final
// word adds eight output transfers.
// Reset (synchronous, rst_n low) loads the IV and empties the block; no clearing pass.
// Depends on sm3_pkg and sm3_round.
module sm3_hash_engine (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_message_word,
  input  logic        in_final_word,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic        out_digest_last
);

  // Control state. The engine accepts words only while idle. Words are shifted
  // into a sixteen-word window; the sixteenth word of a block starts the rounds.
  sm3_pkg::state_t  state_r,   state_nxt;
  logic [3:0]       pos_r,     pos_nxt;
  logic [5:0]       round_r,   round_nxt;
  logic [2:0]       emit_r,    emit_nxt;
  logic             final_r,   final_nxt;

  // Datapath: chaining value, working registers A..H and the message window.
  sm3_pkg::regs_t   cv_r,      cv_nxt;
  sm3_pkg::regs_t   wr_r,      wr_nxt;
  sm3_pkg::window_t win_r,     win_nxt;

  sm3_pkg::regs_t   round_out;
  logic             in_xfer;
  logic             out_xfer;

  // The shared round unit. During rounds the window holds W[j] .. W[j+15], so
  // the unit always reads W[j] and W[j+4] at fixed taps.
  sm3_round u_round (
    .v     (wr_r),
    .w_j   (win_r[0]),
    .w_j4  (win_r[4]),
    .j     (round_r),
    .v_nxt (round_out)
  );

  assign in_stall        = (state_r != sm3_pkg::S_IDLE);
  assign out_valid       = (state_r == sm3_pkg::S_EMIT);
  assign out_digest_word = cv_r[0];
  assign out_digest_last = (emit_r == 3'd7);

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    round_nxt = round_r;
    emit_nxt  = emit_r;
    final_nxt = final_r;
    cv_nxt    = cv_r;
    wr_nxt    = wr_r;
    win_nxt   = win_r;

    case (state_r)
      sm3_pkg::S_IDLE: begin
        if (in_xfer) begin
          // Every word is shifted in, even one that ends an incomplete block;
          // that partial block is simply dropped afterwards.
          win_nxt = {win_r[1:15], in_message_word};
          if (pos_r == 4'(sm3_pkg::BLOCK_WORDS - 1)) begin
            // A full block: start the rounds from the current chaining value.
            pos_nxt   = 4'd0;
            round_nxt = 6'd0;
            wr_nxt    = cv_r;
            final_nxt = in_final_word;
            state_nxt = sm3_pkg::S_ROUND;
          end else if (in_final_word) begin
            // Final word inside a partial block: the digest is the chaining
            // value as it stands.
            pos_nxt   = 4'd0;
            emit_nxt  = 3'd0;
            state_nxt = sm3_pkg::S_EMIT;
          end else begin
            pos_nxt = pos_r + 4'd1;
          end
        end
      end

      sm3_pkg::S_ROUND: begin
        wr_nxt    = round_out;
        win_nxt   = {win_r[1:15], sm3_pkg::expand(win_r)};
        round_nxt = round_r + 6'd1;
        if (round_r == 6'(sm3_pkg::ROUNDS - 1)) begin
          // Last round: fold the result into the chaining value.
          round_nxt = 6'd0;
          for (int k = 0; k < 8; k++) begin
            cv_nxt[k] = cv_r[k] ^ round_out[k];
          end
          wr_nxt = cv_nxt;
          if (final_r) begin
            emit_nxt  = 3'd0;
            state_nxt = sm3_pkg::S_EMIT;
          end else begin
            state_nxt = sm3_pkg::S_IDLE;
          end
          final_nxt = 1'b0;
        end
      end

      sm3_pkg::S_EMIT: begin
        // The chaining value shifts toward word 0, which drives the output.
        if (out_xfer) begin
          cv_nxt   = {cv_r[1:7], cv_r[0]};
          emit_nxt = emit_r + 3'd1;
          if (emit_r == 3'(sm3_pkg::DIGEST_WORDS - 1)) begin
            // Digest delivered: back to the IV for the next message.
            cv_nxt    = sm3_pkg::IV;
            wr_nxt    = sm3_pkg::IV;
            emit_nxt  = 3'd0;
            state_nxt = sm3_pkg::S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = sm3_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sm3_pkg::S_IDLE;
      pos_r   <= 4'd0;
      round_r <= 6'd0;
      emit_r  <= 3'd0;
      final_r <= 1'b0;
      cv_r    <= sm3_pkg::IV;
      wr_r    <= sm3_pkg::IV;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      round_r <= round_nxt;
      emit_r  <= emit_nxt;
      final_r <= final_nxt;
      cv_r    <= cv_nxt;
      wr_r    <= wr_nxt;
    end
  end

  // The window holds message data only and needs no reset.
  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

`ifndef ASSERT_OFF
  // A completed block always starts the rounds at round zero.
  a_block_starts_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && pos_r == 4'd15) |=> (state_r == sm3_pkg::S_ROUND && round_r == 6'd0))
    else $error("completed block did not start the rounds");

  // The round phase ends after the last round.
  a_rounds_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sm3_pkg::S_ROUND && round_r == 6'd63) |=> (state_r != sm3_pkg::S_ROUND))
    else $error("round phase ran past the last round");

  // The round counter is parked at zero outside the round phase.
  a_round_parked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != sm3_pkg::S_ROUND) |-> (round_r == 6'd0))
    else $error("round counter not zero outside rounds");

  // After the last digest word the engine is idle with the IV restored.
  a_digest_restores_iv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_digest_last) |=>
      (state_r == sm3_pkg::S_IDLE && pos_r == 4'd0 && cv_r == sm3_pkg::IV))
    else $error("engine not back at the IV after the digest");
`endif

endmodule
